>>> hw/rtl/lnds_pkg.sv
package lnds_pkg;

  localparam int SAMPLE_W      = 32;
  localparam int LEN_W         = 11;
  localparam int OUT_DATA_W    = 24;
  localparam int MAX_ITEMS_DEF = 1024;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;   // latch the incoming item and apply its start request
    logic issue;    // read the store entry at the scan address and advance it
    logic commit;   // store the result unless the store is full, and load the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;       // every store entry of the current sequence is taken
    logic empty;      // no earlier value in the current sequence
    logic scan_last;  // the scan address points at the newest stored entry
    logic out_free;   // the output register can take a result this cycle
  } status_t;

endpackage

>>> hw/rtl/lnds_ram.sv
module lnds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/lnds_ctrl.sv
module lnds_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  lnds_pkg::status_t status,
  output lnds_pkg::cmd_t    cmd
);

  import lnds_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cmd.accept = 1'b0;
    cmd.issue  = 1'b0;
    cmd.commit = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.full || status.empty) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (status.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hw/rtl/lnds_datapath.sv
module lnds_datapath #(
  parameter int MAX_ITEMS = lnds_pkg::MAX_ITEMS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [lnds_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                         in_start,
  input  lnds_pkg::cmd_t                cmd,
  output lnds_pkg::status_t             status,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lnds_pkg::LEN_W-1:0]    out_ending,
  output logic [lnds_pkg::LEN_W-1:0]    out_best,
  output logic                         out_overflow
);

  import lnds_pkg::*;

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int DW = SAMPLE_W + CW;

  logic signed [SAMPLE_W-1:0] sample_r;
  logic [CW-1:0]              len_r;
  logic [CW-1:0]              count_r;
  logic [CW-1:0]              best_r;
  logic [CW-1:0]              addr_r;
  logic                       rd_valid_r;

  logic                       out_valid_r;
  logic [LEN_W-1:0]           out_ending_r;
  logic [LEN_W-1:0]           out_best_r;
  logic                       out_overflow_r;

  logic [DW-1:0]              rdata;
  logic signed [SAMPLE_W-1:0] rd_value;
  logic [CW-1:0]              rd_len;
  logic [CW-1:0]              rd_len_inc;
  logic [CW-1:0]              best_nxt;
  logic                       store_we;

  assign rd_value   = $signed(rdata[SAMPLE_W-1:0]);
  assign rd_len     = rdata[DW-1:SAMPLE_W];
  assign rd_len_inc = CW'(rd_len + 1'b1);
  assign best_nxt   = (len_r > best_r) ? len_r : best_r;
  assign store_we   = cmd.commit && !status.full;

  assign status.full      = (count_r == CW'(MAX_ITEMS));
  assign status.empty     = (count_r == '0);
  assign status.scan_last = (addr_r == CW'(count_r - 1'b1));
  assign status.out_free  = !out_valid_r || out_ready;

  lnds_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (count_r[AW-1:0]),
    .wdata ({len_r, sample_r}),
    .raddr (addr_r[AW-1:0]),
    .rdata (rdata)
  );

  // Item registers and the compare-and-keep step of the scan.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_r <= $signed(in_sample);
      len_r    <= CW'(1);
      addr_r   <= '0;
    end else begin
      if (cmd.issue) begin
        addr_r <= CW'(addr_r + 1'b1);
      end
      if (rd_valid_r && (rd_value <= sample_r) && (rd_len_inc > len_r)) begin
        len_r <= rd_len_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
      count_r    <= '0;
      best_r     <= '0;
    end else begin
      rd_valid_r <= cmd.issue;
      if (cmd.accept && in_start) begin
        count_r <= '0;
        best_r  <= '0;
      end else if (store_we) begin
        count_r <= CW'(count_r + 1'b1);
        best_r  <= best_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (status.full) begin
        out_ending_r   <= '0;
        out_best_r     <= LEN_W'(best_r);
        out_overflow_r <= 1'b1;
      end else begin
        out_ending_r   <= LEN_W'(len_r);
        out_best_r     <= LEN_W'(best_nxt);
        out_overflow_r <= 1'b0;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_ending   = out_ending_r;
  assign out_best     = out_best_r;
  assign out_overflow = out_overflow_r;

endmodule

>>> hw/rtl/longest_nondecreasing_subseq_core.sv
// Longest non-decreasing subsequence engine. Each input item carries one signed
// 32-bit sample and a start flag; a set start flag begins a new sequence before
// that sample is handled. For every item the core returns one result item: the
// length of the longest non-decreasing subsequence that ends at the sample, the
// longest length seen so far in the sequence, and an overflow flag. Up to
// MAX_ITEMS samples per sequence are kept; a sample beyond that is dropped and
// returns a length of zero with the overflow flag set. Items are handled one
// at a time. With n samples already stored, an accepted item is checked, scans
// the n stored entries and is committed; the scan is skipped when n is zero or the
// store is full, so the cost is set by the scan that reads one stored entry per cycle
// through the single read port of the sample store. A finished result waits in
// an output register, so the next item is accepted while it is still pending.

module longest_nondecreasing_subseq_core #(
  parameter int MAX_ITEMS = lnds_pkg::MAX_ITEMS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [lnds_pkg::SAMPLE_W-1:0]   in_tdata,   // [31:0] sample
  input  logic                            in_tuser,   // [0] start_req
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [lnds_pkg::OUT_DATA_W-1:0] out_tdata,  // [10:0] ending_length,
                                                      // [21:11] best_length, [23:22] zero
  output logic                            out_tuser   // [0] overflow
);

  import lnds_pkg::*;

  cmd_t             cmd;
  status_t          status;
  logic [LEN_W-1:0] out_ending;
  logic [LEN_W-1:0] out_best;

  // The controller sequences acceptance, the store scan and the result hand-off.
  lnds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the store, the running counts and the output register.
  lnds_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_sample    (in_tdata),
    .in_start     (in_tuser),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_ending   (out_ending),
    .out_best     (out_best),
    .out_overflow (out_tuser)
  );

  // Result fields are packed from the lowest bit up, padded to whole bytes.
  assign out_tdata = {{(OUT_DATA_W - 2 * LEN_W){1'b0}}, out_best, out_ending};

endmodule

>>> hw/rtl/lnds_checker.sv
module lnds_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tuser
);

  // Nothing is offered on the result side straight after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

  // An accepted item keeps the core busy for at least the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("item accepted while the previous one was still starting");

  // A dropped sample reports no length; a stored one reports a length between
  // one and the running best.
  a_length_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser ? (out_tdata[10:0] == 11'd0)
                              : ((out_tdata[10:0] != 11'd0) &&
                                 (out_tdata[10:0] <= out_tdata[21:11]))))
    else $error("inconsistent result lengths");

  // A stalled result holds still.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) &&
                                     $stable(out_tuser)))
    else $error("stalled result changed");

endmodule

bind longest_nondecreasing_subseq_core lnds_checker u_lnds_checker (.*);
